>>> src/multi_beam_break_detector_defines.svh
// Assertion macros shared by the beam-break detector RTL.
// Needs nothing else; assertions drop out when SYNTHESIS is defined.
`ifndef MULTI_BEAM_BREAK_DETECTOR_DEFINES_SVH
`define MULTI_BEAM_BREAK_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MBBD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mbbd assertion failed");
`define MBBD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("mbbd assertion failed");
`else
`define MBBD_ASSERT(lbl, clk, rst, prop)
`define MBBD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/mbbd_pkg.sv
// Shared types, constants and helpers of the beam-break detector.
// Used by mbbd_tick, mbbd_emit and the top level; depends on nothing.
`default_nettype none
package mbbd_pkg;

   localparam int SAMPLE_FIELDS  = 7;
   localparam int PEND_BITS      = 7;
   localparam int NUM_BITS       = 3;
   localparam int THR_BITS       = 12;
   localparam int COOL_BITS      = 16;
   localparam int TIME_BITS      = 32;
   localparam int CMD_BITS       = 2;
   localparam int BYTE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CONTROL = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DRAIN   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COOLDOWN  = 2'd1;

   localparam logic [THR_BITS-1:0]  THRESHOLD_RESET = 12'd2481;
   localparam logic [COOL_BITS-1:0] COOLDOWN_RESET  = 16'd100;

   localparam logic [BYTE_BITS-1:0] START_BYTE = 8'hAA;
   localparam logic [BYTE_BITS-1:0] END_BYTE   = 8'hBB;

   typedef struct packed {
      logic                 busy;
      logic [PEND_BITS-1:0] set_mask;
   } tick_stat_type;

   function automatic logic [NUM_BITS-1:0] beam_index(input logic [PEND_BITS-1:0] code);
      logic [NUM_BITS-1:0] idx;
      idx = '0;
      for (int i = 0; i < PEND_BITS; i++) begin
         if (code[i]) begin
            idx = NUM_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

>>> src/mbbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mbbd_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 7
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/mbbd_tick.sv
// Tick engine: walks the channels through the per-beam state RAM,
// read, qualify and write back. Depends on mbbd_pkg and mbbd_ram.
`default_nettype none
module mbbd_tick #(
   parameter int BEAM_COUNT  = 7,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic [mbbd_pkg::TIME_BITS-1:0]           now_ms,
   input  wire logic [mbbd_pkg::SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] samples,
   input  wire logic [mbbd_pkg::THR_BITS-1:0]            threshold,
   input  wire logic [mbbd_pkg::COOL_BITS-1:0]           cooldown,
   output mbbd_pkg::tick_stat_type                       stat
);

   localparam int ADDR_BITS  = $clog2(BEAM_COUNT + 1);
   localparam int IDX_BITS   = (BEAM_COUNT > 1) ? $clog2(BEAM_COUNT) : 1;
   localparam int ENTRY_BITS = mbbd_pkg::TIME_BITS + 1;
   localparam int SEL_BITS   = mbbd_pkg::NUM_BITS;

   logic                          busy_ff, busy_in;
   logic [ADDR_BITS-1:0]          cnt_ff, cnt_in;
   logic                          rd_issue_ff;
   logic [IDX_BITS-1:0]           rd_idx_ff;
   logic                          rd_known_ff;
   logic [BEAM_COUNT-1:0]         valid_ff;
   logic [mbbd_pkg::TIME_BITS-1:0] now_ff;
   logic [mbbd_pkg::SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] samp_ff;

   logic                          rd_en;
   logic [IDX_BITS-1:0]           rd_addr;
   logic [ENTRY_BITS-1:0]         rd_data;
   logic [ENTRY_BITS-1:0]         entry;
   logic                          old_in;
   logic [mbbd_pkg::TIME_BITS-1:0] old_time;
   logic [mbbd_pkg::TIME_BITS-1:0] elapsed;
   logic [SEL_BITS-1:0]           sel;
   logic                          has_sample;
   logic [SAMPLE_BITS-1:0]        sample;
   logic                          blocked;
   logic                          fire;
   logic                          wr_en;
   logic [ENTRY_BITS-1:0]         wr_data;

   assign rd_en   = busy_ff && (cnt_ff != ADDR_BITS'(BEAM_COUNT));
   assign rd_addr = IDX_BITS'(cnt_ff);
   assign busy_in = start || rd_en;

   always_comb begin
      cnt_in = cnt_ff;
      if (start) begin
         cnt_in = '0;
      end else if (rd_en) begin
         cnt_in = cnt_ff + ADDR_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
         rd_issue_ff <= 1'b0;
         valid_ff    <= '0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         rd_issue_ff <= rd_en;
         if (wr_en) begin
            valid_ff[rd_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_addr;
      rd_known_ff <= valid_ff[rd_addr];
      if (start) begin
         now_ff  <= now_ms;
         samp_ff <= samples;
      end
   end

   mbbd_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (BEAM_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      entry      = rd_known_ff ? rd_data : '0;
      old_in     = entry[mbbd_pkg::TIME_BITS];
      old_time   = entry[mbbd_pkg::TIME_BITS-1:0];
      elapsed    = now_ff - old_time;
      sel        = SEL_BITS'(rd_idx_ff);
      has_sample = (32'(sel) < mbbd_pkg::SAMPLE_FIELDS);
      sample     = has_sample ? samp_ff[sel] : '0;
      blocked    = has_sample && (32'(sample) < 32'(threshold));
      fire       = rd_issue_ff && blocked && !old_in &&
                   (elapsed > mbbd_pkg::TIME_BITS'(cooldown));
      wr_en      = fire || (rd_issue_ff && !blocked && old_in);
      wr_data    = fire ? {1'b1, now_ff} : {1'b0, old_time};
   end

   assign stat.busy     = busy_ff;
   assign stat.set_mask = fire ? (mbbd_pkg::PEND_BITS'(1) << sel) : '0;

endmodule
`default_nettype wire

>>> src/mbbd_emit.sv
// Drain emitter: hands out one transaction per fired beam, lowest first,
// through the output register. Depends on mbbd_pkg.
`default_nettype none
module mbbd_emit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [mbbd_pkg::PEND_BITS-1:0] mask,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic      [mbbd_pkg::PEND_BITS-1:0] rsp_beam_code,
   output logic      [mbbd_pkg::NUM_BITS-1:0]  rsp_beam_number,
   output logic                                rsp_last_of_run,
   output logic                                busy
);

   logic [mbbd_pkg::PEND_BITS-1:0] mask_ff, mask_in;
   logic                           valid_ff, valid_in;
   logic [mbbd_pkg::PEND_BITS-1:0] code_ff;
   logic [mbbd_pkg::NUM_BITS-1:0]  number_ff;
   logic                           last_ff;
   logic [mbbd_pkg::PEND_BITS-1:0] low;
   logic [mbbd_pkg::PEND_BITS-1:0] rest;
   logic                           load;

   always_comb begin
      low      = mask_ff & (~mask_ff + mbbd_pkg::PEND_BITS'(1));
      rest     = mask_ff & ~low;
      load     = (mask_ff != '0) && (!valid_ff || !rsp_stall);
      mask_in  = mask_ff;
      valid_in = valid_ff;
      if (start) begin
         mask_in = mask;
      end else if (load) begin
         mask_in = rest;
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff   <= low;
         number_ff <= mbbd_pkg::beam_index(low);
         last_ff   <= (rest == '0);
      end
   end

   assign busy            = (mask_ff != '0);
   assign rsp_valid       = valid_ff;
   assign rsp_beam_code   = code_ff;
   assign rsp_beam_number = number_ff;
   assign rsp_last_of_run = last_ff;

endmodule
`default_nettype wire

>>> src/multi_beam_break_detector.sv
// Top level of the multi-beam break detector: command decode, settings,
// pending mask and game flag. Depends on mbbd_pkg, mbbd_tick, mbbd_emit.
//
// A tick transaction stalls requests until every channel is walked: each
// channel's in-beam flag and last fire time sit in one state RAM, read
// one channel per cycle and written back, when it changes, in the
// following cycle. Control transactions, and drains that send nothing,
// do not stall. Otherwise a drain emits one response per fired beam, one
// per cycle while rsp_stall is low, and requests stall until the last one
// is loaded into the output register. State clears at reset through
// per-channel valid bits, with no clearing pass. csr_ready is always high.
`default_nettype none
`include "multi_beam_break_detector_defines.svh"
module multi_beam_break_detector #(
   parameter int BEAM_COUNT  = 7,
   parameter int SAMPLE_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [mbbd_pkg::CMD_BITS-1:0]       req_cmd,
   input  wire logic [mbbd_pkg::TIME_BITS-1:0]      req_now_ms,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_a,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_b,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_c,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_d,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_e,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_f,
   input  wire logic [SAMPLE_BITS-1:0]              req_sample_g,
   input  wire logic [mbbd_pkg::BYTE_BITS-1:0]      req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [mbbd_pkg::PEND_BITS-1:0]      rsp_beam_code,
   output logic      [mbbd_pkg::NUM_BITS-1:0]       rsp_beam_number,
   output logic                                     rsp_last_of_run,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [mbbd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mbbd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [mbbd_pkg::THR_BITS-1:0]  thr_ff, thr_in;
   logic [mbbd_pkg::COOL_BITS-1:0] cool_ff, cool_in;
   logic                           game_on_ff, game_on_in;
   logic [mbbd_pkg::PEND_BITS-1:0] pend_ff, pend_in;

   logic                           accept;
   logic                           tick_start;
   logic                           drain;
   logic                           emit_start;
   logic                           emit_busy;
   mbbd_pkg::tick_stat_type        tick_stat;
   logic [mbbd_pkg::SAMPLE_FIELDS-1:0][SAMPLE_BITS-1:0] samples;

   assign samples[0] = req_sample_a;
   assign samples[1] = req_sample_b;
   assign samples[2] = req_sample_c;
   assign samples[3] = req_sample_d;
   assign samples[4] = req_sample_e;
   assign samples[5] = req_sample_f;
   assign samples[6] = req_sample_g;

   assign csr_ready  = 1'b1;
   assign req_stall  = tick_stat.busy || emit_busy;
   assign accept     = req_valid && !req_stall;
   assign tick_start = accept && (req_cmd == mbbd_pkg::CMD_TICK);
   assign drain      = accept && (req_cmd == mbbd_pkg::CMD_DRAIN);
   assign emit_start = drain && game_on_ff && (pend_ff != '0);

   always_comb begin
      game_on_in = game_on_ff;
      if (accept) begin
         case (req_cmd)
            mbbd_pkg::CMD_CONTROL: begin
               if (req_rx_byte == mbbd_pkg::START_BYTE) begin
                  game_on_in = 1'b1;
               end else if (req_rx_byte == mbbd_pkg::END_BYTE) begin
                  game_on_in = 1'b0;
               end
            end
            default: begin
               game_on_in = game_on_ff;
            end
         endcase
      end
      pend_in = drain ? '0 : (pend_ff | tick_stat.set_mask);
   end

   always_comb begin
      thr_in  = thr_ff;
      cool_in = cool_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            mbbd_pkg::REG_THRESHOLD: thr_in  = csr_wdata[mbbd_pkg::THR_BITS-1:0];
            mbbd_pkg::REG_COOLDOWN:  cool_in = csr_wdata[mbbd_pkg::COOL_BITS-1:0];
            default: begin
               thr_in  = thr_ff;
               cool_in = cool_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= mbbd_pkg::THRESHOLD_RESET;
         cool_ff    <= mbbd_pkg::COOLDOWN_RESET;
         game_on_ff <= 1'b0;
         pend_ff    <= '0;
      end else begin
         thr_ff     <= thr_in;
         cool_ff    <= cool_in;
         game_on_ff <= game_on_in;
         pend_ff    <= pend_in;
      end
   end

   mbbd_tick #(
      .BEAM_COUNT  (BEAM_COUNT),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tick (
      .clock     (clock),
      .reset     (reset),
      .start     (tick_start),
      .now_ms    (req_now_ms),
      .samples   (samples),
      .threshold (thr_ff),
      .cooldown  (cool_ff),
      .stat      (tick_stat)
   );

   mbbd_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .start           (emit_start),
      .mask            (pend_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_beam_code   (rsp_beam_code),
      .rsp_beam_number (rsp_beam_number),
      .rsp_last_of_run (rsp_last_of_run),
      .busy            (emit_busy)
   );

   `MBBD_ASSERT(a_tick_emit_excl, clock, reset, !(tick_stat.busy && emit_busy))
   `MBBD_ASSERT(a_drain_clears, clock, reset, drain |=> (pend_ff == '0))
   `MBBD_ASSERT(a_off_no_emit, clock, reset, (drain && !game_on_ff) |=> !emit_busy)
   `MBBD_ASSERT(a_tick_busy, clock, reset, tick_start |=> tick_stat.busy)

endmodule
`default_nettype wire
